FILE: src/sjf_pkg.sv
// Shared types and constants for the shortest-job-first schedule timing unit.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sjf_pkg;

    localparam int ID_W          = 8;
    localparam int TIME_W        = 16;
    localparam int CLK_W         = 22;
    localparam int MAX_PROCS_DEF = 32;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
    } job_t;

    typedef struct packed {
        logic              is_idle;
        logic [ID_W-1:0]   job_id_res;
        logic [TIME_W-1:0] duration;
        logic [CLK_W-1:0]  completion;
        logic [CLK_W-1:0]  turnaround;
        logic [CLK_W-1:0]  waiting;
        logic              last_segment;
    } seg_t;

    typedef struct packed {
        logic load;
        logic scan_clear;
        logic scan_issue;
        logic emit;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic run_done;
        logic out_busy;
    } stat_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_FLUSH,
        ST_DECIDE,
        ST_HOLD
    } state_t;

endpackage

`default_nettype wire

FILE: src/sjf_if.sv
// Valid/ready channel interfaces for job beats in and segment beats out.
// Depends on sjf_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sjf_job_if
    import sjf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   job_id;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic              last_job;

    modport source (output valid, job_id, arrival, burst, last_job, input ready);
    modport sink   (input valid, job_id, arrival, burst, last_job, output ready);
endinterface

interface sjf_seg_if
    import sjf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              is_idle;
    logic [ID_W-1:0]   job_id_res;
    logic [TIME_W-1:0] duration;
    logic [CLK_W-1:0]  completion;
    logic [CLK_W-1:0]  turnaround;
    logic [CLK_W-1:0]  waiting;
    logic              last_segment;

    modport source (output valid, is_idle, job_id_res, duration, completion,
                    turnaround, waiting, last_segment, input ready);
    modport sink   (input valid, is_idle, job_id_res, duration, completion,
                    turnaround, waiting, last_segment, output ready);
endinterface

`default_nettype wire

FILE: src/sjf_ctrl.sv
// Controller state machine: sequences loading, table scans and segment output.
// Depends on sjf_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module sjf_ctrl
    import sjf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire logic  in_last,
    output logic       in_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && in_last)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:  state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_HOLD;
            ST_HOLD:
            begin
                if (!stat.out_busy)
                begin
                    state_next = stat.run_done ? ST_LOAD : ST_SCAN;
                end
            end
            default:   state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready       = 1'b1;
                cmd.load       = in_valid;
                cmd.scan_clear = in_valid && in_last;
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
            end
            ST_FLUSH:
            begin
            end
            ST_DECIDE:
            begin
                cmd.emit = 1'b1;
            end
            ST_HOLD:
            begin
                cmd.finish     = !stat.out_busy && stat.run_done;
                cmd.scan_clear = !stat.out_busy && !stat.run_done;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/sjf_dp.sv
// Datapath: job table memory, selection scan, run clock and segment output register.
// Depends on sjf_pkg for the job, segment, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module sjf_dp
    import sjf_pkg::*;
#(
    parameter int MAX_PROCS = MAX_PROCS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cmd_t  cmd,
    input  wire job_t  in_job,
    input  wire logic  out_ready,
    output stat_t      stat,
    output seg_t       out_seg,
    output logic       out_valid
);

    localparam int IDXW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNTW = $clog2(MAX_PROCS + 1);

    job_t                 table_mem [MAX_PROCS];
    job_t                 rd_reg;
    logic                 rd_valid_reg;
    logic [IDXW-1:0]      rd_idx_reg;
    logic [IDXW-1:0]      addr_reg;
    logic [CNTW-1:0]      count_reg;
    logic [CNTW-1:0]      done_reg;
    logic [MAX_PROCS-1:0] fin_reg;
    logic [CLK_W-1:0]     clock_reg;
    logic                 best_valid_reg;
    logic [IDXW-1:0]      best_idx_reg;
    job_t                 best_reg;
    logic [TIME_W-1:0]    min_arr_reg;
    seg_t                 out_reg;
    logic                 out_valid_reg;

    logic                 arrived;
    logic                 better;
    logic                 live;
    logic [CLK_W-1:0]     comp;
    logic [CNTW-1:0]      done_inc;
    logic [CNTW-1:0]      count_m1;

    assign live     = rd_valid_reg && !fin_reg[rd_idx_reg];
    assign arrived  = CLK_W'(rd_reg.arrival) <= clock_reg;
    assign better   = !best_valid_reg || (rd_reg.burst < best_reg.burst) ||
                      ((rd_reg.burst == best_reg.burst) &&
                       (rd_reg.arrival < best_reg.arrival));
    assign comp     = clock_reg + CLK_W'(best_reg.burst);
    assign done_inc = done_reg + 1'b1;
    assign count_m1 = count_reg - 1'b1;

    assign stat.scan_last = CNTW'(addr_reg) == count_m1;
    assign stat.run_done  = done_reg == count_reg;
    assign stat.out_busy  = out_valid_reg;
    assign out_seg        = out_reg;
    assign out_valid      = out_valid_reg;

    // Table memory: one write port for loading, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (cmd.load && (count_reg < CNTW'(MAX_PROCS)))
        begin
            table_mem[count_reg[IDXW-1:0]] <= in_job;
        end
        if (cmd.scan_issue)
        begin
            rd_reg <= table_mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            rd_idx_reg     <= '0;
            addr_reg       <= '0;
            count_reg      <= '0;
            done_reg       <= '0;
            fin_reg        <= '0;
            clock_reg      <= '0;
            best_valid_reg <= 1'b0;
            best_idx_reg   <= '0;
            min_arr_reg    <= '1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_issue;
            rd_idx_reg   <= addr_reg;
            if (cmd.load && (count_reg < CNTW'(MAX_PROCS)))
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.scan_clear)
            begin
                addr_reg       <= '0;
                best_valid_reg <= 1'b0;
                min_arr_reg    <= '1;
            end
            else if (cmd.scan_issue)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (live)
            begin
                if (rd_reg.arrival < min_arr_reg)
                begin
                    min_arr_reg <= rd_reg.arrival;
                end
                if (arrived && better)
                begin
                    best_valid_reg <= 1'b1;
                    best_idx_reg   <= rd_idx_reg;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                if (best_valid_reg)
                begin
                    clock_reg             <= comp;
                    fin_reg[best_idx_reg] <= 1'b1;
                    done_reg              <= done_inc;
                end
                else
                begin
                    clock_reg <= CLK_W'(min_arr_reg);
                end
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.finish)
            begin
                count_reg <= '0;
                done_reg  <= '0;
                fin_reg   <= '0;
                clock_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (live && arrived && better)
        begin
            best_reg <= rd_reg;
        end
        if (cmd.emit)
        begin
            if (best_valid_reg)
            begin
                out_reg.is_idle      <= 1'b0;
                out_reg.job_id_res   <= best_reg.id;
                out_reg.duration     <= best_reg.burst;
                out_reg.completion   <= comp;
                out_reg.turnaround   <= comp - CLK_W'(best_reg.arrival);
                out_reg.waiting      <= clock_reg - CLK_W'(best_reg.arrival);
                out_reg.last_segment <= done_inc == count_reg;
            end
            else
            begin
                out_reg.is_idle      <= 1'b1;
                out_reg.job_id_res   <= '0;
                out_reg.duration     <= min_arr_reg - clock_reg[TIME_W-1:0];
                out_reg.completion   <= CLK_W'(min_arr_reg);
                out_reg.turnaround   <= '0;
                out_reg.waiting      <= '0;
                out_reg.last_segment <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/sjf_schedule_timing_unit.sv
// Non-preemptive shortest-job-first schedule timing unit: controller plus datapath.
// Loading accepts one job beat per cycle. Each segment needs a scan of the N loaded
// jobs through the single table read port, then the flush, decide and hold states and
// the wait for the segment beat to be taken; a run of N jobs emits up to 2 * N segments.
// After the last segment is taken the unit is ready for a new job set.
// Reset clears the job count, run clock and finished flags; table contents are not reset.
`timescale 1ns / 1ps
`default_nettype none

module sjf_schedule_timing_unit
    import sjf_pkg::*;
#(
    parameter int MAX_PROCS = MAX_PROCS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sjf_job_if.sink    job,
    sjf_seg_if.source  seg
);

    cmd_t  cmd;
    stat_t stat;
    job_t  in_job;
    seg_t  out_seg;
    logic  out_valid;

    assign in_job.id      = job.job_id;
    assign in_job.arrival = job.arrival;
    assign in_job.burst   = job.burst;

    sjf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (job.valid),
        .in_last  (job.last_job),
        .in_ready (job.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sjf_dp #(
        .MAX_PROCS (MAX_PROCS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_job    (in_job),
        .out_ready (seg.ready),
        .stat      (stat),
        .out_seg   (out_seg),
        .out_valid (out_valid)
    );

    assign seg.valid        = out_valid;
    assign seg.is_idle      = out_seg.is_idle;
    assign seg.job_id_res   = out_seg.job_id_res;
    assign seg.duration     = out_seg.duration;
    assign seg.completion   = out_seg.completion;
    assign seg.turnaround   = out_seg.turnaround;
    assign seg.waiting      = out_seg.waiting;
    assign seg.last_segment = out_seg.last_segment;

    // No job beat is taken while a segment beat is still pending.
    assert property (@(posedge clk) disable iff (!rst_n) job.ready |-> !seg.valid)
        else $error("job accepted while segment pending");

    // A decision always presents a segment beat in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |=> seg.valid)
        else $error("decision without segment beat");

    // Loading happens only on an accepted job beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (job.valid && job.ready))
        else $error("table load without accepted beat");

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for sjf_schedule_timing_unit: a directed table of job beats,
// then random sets, checked beat by beat against typed rows or an in-bench SJF predictor.
// Depends on sjf_pkg and the sjf_job_if / sjf_seg_if channel interfaces.
`timescale 1ns / 1ps

module testbench;
    import sjf_pkg::*;

    localparam int TOTAL_ITEMS = 430;
    localparam int QUIET_TAIL  = 50;
    localparam int HOLD_CYCLES = 600;
    localparam int HOLD_AFTER  = 120;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic              last;
        logic              typed;
        logic              e_idle;
        logic [ID_W-1:0]   e_id;
        logic [TIME_W-1:0] e_dur;
        logic [CLK_W-1:0]  e_comp;
        logic [CLK_W-1:0]  e_tat;
        logic [CLK_W-1:0]  e_wait;
        logic              e_last;
    } dir_row_t;

    localparam int N_DIRECTED = 17;
    localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{8'd255, 16'd0,     16'd65535, 1'b1, 1'b1, 1'b0, 8'd255, 16'd65535,
          22'd65535, 22'd65535, 22'd0, 1'b1},
        '{8'd9,   16'd0,     16'd0,     1'b1, 1'b1, 1'b0, 8'd9,   16'd0,
          22'd0, 22'd0, 22'd0, 1'b1},
        '{8'd0,   16'd65535, 16'd0,     1'b1, 1'b0, 1'b0, 8'd0, 16'd0, 22'd0, 22'd0, 22'd0, 1'b0},
        '{8'd128, 16'd65535, 16'd65535, 1'b1, 1'b0, 1'b0, 8'd0, 16'd0, 22'd0, 22'd0, 22'd0, 1'b0},
        '{8'd1,   16'd0,     16'd10,    1'b0, 1'b0, 1'b0, 8'd0, 16'd0, 22'd0, 22'd0, 22'd0, 1'b0},
        '{8'd2,   16'd3,     16'd4,     1'b0, 1'b0, 1'b0, 8'd0, 16'd0, 22'd0, 22'd0, 22'd0, 1'b0},
        '{8'd3,   16'd3,     16'd4,     1'b0, 1'b0, 1'b0, 8'd0, 16'd0, 22'd0, 22'd0, 22'd0, 1'b0},
        '{8'd4,   16'd2,     16'd4,     1'b0, 1'b0, 1'b0, 8'd0, 16'd0, 22'd0, 22'd0, 22'd0, 1'b0},
        '{8'd5,   16'd100,   16'd0,     1'b0, 1'b0, 1'b0, 8'd0, 16'd0, 22'd0, 22'd0, 22'd0, 1'b0},
        '{8'd6,   16'd40000, 16'd65535, 1'b1, 1'b0, 1'b0, 8'd0, 16'd0, 22'd0, 22'd0, 22'd0, 1'b0},
        '{8'd20,  16'd0,     16'd50,    1'b0, 1'b0, 1'b0, 8'd0, 16'd0, 22'd0, 22'd0, 22'd0, 1'b0},
        '{8'd21,  16'd1,     16'd30,    1'b0, 1'b0, 1'b0, 8'd0, 16'd0, 22'd0, 22'd0, 22'd0, 1'b0},
        '{8'd22,  16'd2,     16'd10,    1'b0, 1'b0, 1'b0, 8'd0, 16'd0, 22'd0, 22'd0, 22'd0, 1'b0},
        '{8'd23,  16'd2,     16'd10,    1'b0, 1'b0, 1'b0, 8'd0, 16'd0, 22'd0, 22'd0, 22'd0, 1'b0},
        '{8'd24,  16'd60,    16'd5,     1'b1, 1'b0, 1'b0, 8'd0, 16'd0, 22'd0, 22'd0, 22'd0, 1'b0},
        '{8'hAA,  16'h5555,  16'hAAAA,  1'b0, 1'b0, 1'b0, 8'd0, 16'd0, 22'd0, 22'd0, 22'd0, 1'b0},
        '{8'h55,  16'hAAAA,  16'h5555,  1'b1, 1'b0, 1'b0, 8'd0, 16'd0, 22'd0, 22'd0, 22'd0, 1'b0}
    };

    logic clk;
    logic rst_n;

    sjf_job_if job_ch ();
    sjf_seg_if seg_ch ();

    sjf_schedule_timing_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .job   (job_ch),
        .seg   (seg_ch)
    );

    job_t        sched_tab [MAX_PROCS_DEF];
    int unsigned sched_count = 0;
    seg_t        expected_segs [$];

    int  mismatches     = 0;
    int  items_sent     = 0;
    int  segs_taken     = 0;
    bit  tail_quiet     = 1'b0;
    bit  send_gaps      = 1'b0;
    bit  long_hold_done = 1'b0;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        #400000;
        $display("testbench: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    endtask

    function automatic void queue_expected(input seg_t s);
        expected_segs = {expected_segs, s};
    endfunction

    // Stores one job and, on the last job of a set, plays the whole non-preemptive
    // shortest-job-first schedule, queuing one segment per idle gap or finished job.
    function automatic void sjf_accept_job(input job_t j, input logic last_flag);
        logic [MAX_PROCS_DEF-1:0] done_mask;
        logic [CLK_W-1:0]         now;
        logic [TIME_W:0]          next;
        int                       best;
        int                       done;
        int                       i;
        seg_t                     s;
        if (sched_count < MAX_PROCS_DEF)
        begin
            sched_tab[sched_count] = j;
            sched_count++;
        end
        if (!last_flag)
            return;
        now       = '0;
        done_mask = '0;
        done      = 0;
        while (done < sched_count)
        begin
            best = -1;
            for (i = 0; i < sched_count; i++)
            begin
                if (!done_mask[i] && sched_tab[i].arrival <= now)
                begin
                    if (best < 0 || sched_tab[i].burst < sched_tab[best].burst ||
                        (sched_tab[i].burst == sched_tab[best].burst &&
                         sched_tab[i].arrival < sched_tab[best].arrival))
                        best = i;
                end
            end
            s = '0;
            if (best < 0)
            begin
                next = '1;
                for (i = 0; i < sched_count; i++)
                    if (!done_mask[i] && sched_tab[i].arrival < next)
                        next = (TIME_W+1)'(sched_tab[i].arrival);
                s.is_idle    = 1'b1;
                s.duration   = TIME_W'(next - now);
                s.completion = CLK_W'(next);
                now          = CLK_W'(next);
            end
            else
            begin
                now             = now + CLK_W'(sched_tab[best].burst);
                done_mask[best] = 1'b1;
                done++;
                s.job_id_res   = sched_tab[best].id;
                s.duration     = sched_tab[best].burst;
                s.completion   = now;
                s.turnaround   = now - CLK_W'(sched_tab[best].arrival);
                s.waiting      = s.turnaround - CLK_W'(sched_tab[best].burst);
                s.last_segment = (done == sched_count);
            end
            queue_expected(s);
        end
        sched_count = 0;
    endfunction

    task automatic offer_job(input job_t j, input logic last_flag, input logic typed,
                             input seg_t typed_seg);
        job_ch.valid    = 1'b1;
        job_ch.job_id   = j.id;
        job_ch.arrival  = j.arrival;
        job_ch.burst    = j.burst;
        job_ch.last_job = last_flag;
        do
            @(posedge clk);
        while (!job_ch.ready);
        items_sent++;
        if (typed)
        begin
            sched_count = 0;
            queue_expected(typed_seg);
        end
        else
            sjf_accept_job(j, last_flag);
        @(negedge clk);
    endtask

    task automatic maybe_gap();
        if (send_gaps && !tail_quiet && $urandom_range(0, 2) == 0)
        begin
            job_ch.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    initial
    begin : stimulus
        job_t     j;
        seg_t     ts;
        dir_row_t r;
        int       set_size;
        int       pick;
        int       arr_mode;
        int       burst_mode;
        int       base;
        int       k;
        bit       first_set;

        job_ch.valid    = 1'b0;
        job_ch.job_id   = '0;
        job_ch.arrival  = '0;
        job_ch.burst    = '0;
        job_ch.last_job = 1'b0;
        first_set       = 1'b1;
        wait (rst_n === 1'b1);
        @(negedge clk);

        send_gaps = 1'b1;
        for (k = 0; k < N_DIRECTED; k++)
        begin
            r  = DIRECTED_ROWS[k];
            j  = '{id: r.id, arrival: r.arrival, burst: r.burst};
            ts = '{is_idle: r.e_idle, job_id_res: r.e_id, duration: r.e_dur,
                   completion: r.e_comp, turnaround: r.e_tat, waiting: r.e_wait,
                   last_segment: r.e_last};
            maybe_gap();
            offer_job(j, r.last, r.typed, ts);
        end

        while (items_sent < TOTAL_ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (first_set || pick == 1)
                set_size = $urandom_range(MAX_PROCS_DEF + 1, MAX_PROCS_DEF + 4);
            else if (pick == 0)
                set_size = MAX_PROCS_DEF;
            else if (pick <= 4)
                set_size = $urandom_range(9, 20);
            else
                set_size = $urandom_range(1, 8);
            first_set  = 1'b0;
            arr_mode   = $urandom_range(0, 2);
            burst_mode = $urandom_range(0, 2);
            base       = $urandom_range(0, 65335);
            send_gaps  = ($urandom_range(0, 2) != 0);
            if (items_sent >= TOTAL_ITEMS - QUIET_TAIL)
                tail_quiet = 1'b1;
            for (k = 0; k < set_size; k++)
            begin
                j.id = ID_W'($urandom_range(0, 255));
                case (arr_mode)
                    0:       j.arrival = TIME_W'($urandom_range(0, 30));
                    1:       j.arrival = TIME_W'($urandom_range(0, 65535));
                    default: j.arrival = TIME_W'(base + $urandom_range(0, 200));
                endcase
                case (burst_mode)
                    0:       j.burst = TIME_W'($urandom_range(0, 8));
                    1:       j.burst = TIME_W'($urandom_range(0, 65535));
                    default:
                    begin
                        case ($urandom_range(0, 3))
                            0:       j.burst = '0;
                            1:       j.burst = '1;
                            default: j.burst = TIME_W'($urandom_range(0, 1000));
                        endcase
                    end
                endcase
                maybe_gap();
                offer_job(j, k == set_size - 1, 1'b0, '0);
            end
        end

        job_ch.valid = 1'b0;
        while (expected_segs.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial
    begin : segment_sink
        int  stall_left;
        int  cyc;
        bit  stall_on;
        stall_left   = 0;
        cyc          = 0;
        stall_on     = 1'b1;
        seg_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 256 == 0)
                stall_on = ($urandom_range(0, 2) != 0);
            if (!long_hold_done && segs_taken >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                seg_ch.ready   = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (stall_on && !tail_quiet && stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 12);
            if (stall_left > 0 && !tail_quiet)
            begin
                seg_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                seg_ch.ready = 1'b1;
                stall_left   = 0;
            end
        end
    end

    always @(posedge clk)
    begin : segment_check
        seg_t got;
        seg_t want;
        if (rst_n && seg_ch.valid && seg_ch.ready)
        begin
            segs_taken++;
            got = '{is_idle: seg_ch.is_idle, job_id_res: seg_ch.job_id_res,
                    duration: seg_ch.duration, completion: seg_ch.completion,
                    turnaround: seg_ch.turnaround, waiting: seg_ch.waiting,
                    last_segment: seg_ch.last_segment};
            if (expected_segs.size() == 0)
                report_mismatch("unexpected segment beat, duration", 32'(got.duration),
                                32'd0);
            else
            begin
                want = expected_segs.pop_front();
                if (got.is_idle !== want.is_idle)
                    report_mismatch("is_idle", 32'(got.is_idle), 32'(want.is_idle));
                if (got.job_id_res !== want.job_id_res)
                    report_mismatch("job_id_res", 32'(got.job_id_res),
                                    32'(want.job_id_res));
                if (got.duration !== want.duration)
                    report_mismatch("duration", 32'(got.duration), 32'(want.duration));
                if (got.completion !== want.completion)
                    report_mismatch("completion", 32'(got.completion),
                                    32'(want.completion));
                if (got.turnaround !== want.turnaround)
                    report_mismatch("turnaround", 32'(got.turnaround),
                                    32'(want.turnaround));
                if (got.waiting !== want.waiting)
                    report_mismatch("waiting", 32'(got.waiting), 32'(want.waiting));
                if (got.last_segment !== want.last_segment)
                    report_mismatch("last_segment", 32'(got.last_segment),
                                    32'(want.last_segment));
            end
        end
    end

endmodule
